// ----- rtl/core/spq_pkg.sv -----
package spq_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int PRIO_W           = 16;
   localparam int PAYLOAD_W        = 32;
   localparam int OCC_W            = 5;
   localparam int STATUS_W         = 2;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 2'd0,
      STATUS_EMPTY_REMOVE = 2'd1,
      STATUS_FULL_INSERT  = 2'd2
   } status_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      logic                        ins_en;
      logic [PRIO_W-1:0]           prio;
      logic signed [PAYLOAD_W-1:0] payload;
   } cell_ctrl_type;

endpackage

// ----- rtl/core/spq_cell.sv -----
module spq_cell (
   input  logic                                 clock,
   input  spq_pkg::cell_ctrl_type               ctrl,
   input  logic                                 occupied,
   input  logic                                 left_keep,
   input  logic [spq_pkg::PRIO_W-1:0]           left_prio,
   input  logic signed [spq_pkg::PAYLOAD_W-1:0] left_payload,
   output logic                                 keep,
   output logic [spq_pkg::PRIO_W-1:0]           prio,
   output logic signed [spq_pkg::PAYLOAD_W-1:0] payload
);

   logic [spq_pkg::PRIO_W-1:0]           prio_ff, prio_in;
   logic signed [spq_pkg::PAYLOAD_W-1:0] payload_ff, payload_in;

   // Keep the entry when it sits below the insertion point.
   assign keep = occupied && (prio_ff <= ctrl.prio);

   always_comb begin
      prio_in    = prio_ff;
      payload_in = payload_ff;
      if (ctrl.ins_en && !keep) begin
         if (left_keep) begin
            prio_in    = ctrl.prio;
            payload_in = ctrl.payload;
         end else begin
            prio_in    = left_prio;
            payload_in = left_payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      prio_ff    <= prio_in;
      payload_ff <= payload_in;
   end

   assign prio    = prio_ff;
   assign payload = payload_ff;

endmodule

// ----- rtl/core/sorted_priority_queue.sv -----
// Channel | Direction | Handshake           | Fields
// req_    | in        | req_valid/req_stall | req_opcode, req_prio, req_payload
// rsp_    | out       | rsp_valid/rsp_stall | rsp_top_payload, rsp_top_prio,
//         |           |                     | rsp_is_empty, rsp_is_full,
//         |           |                     | rsp_occupancy, rsp_status
//
// The cell chain updates at the accepting edge; the tail select then loads
// the response register once that register is free.
// No new request is taken while the last one is still pending in the chain.
// reset (synchronous) empties the queue and drops any response in flight.
// A stalled response holds; the next request is still taken, its response
// waits in the chain until the output register frees.
module sorted_priority_queue #(
   parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_opcode,
   input  logic [spq_pkg::PRIO_W-1:0]            req_prio,
   input  logic signed [spq_pkg::PAYLOAD_W-1:0]  req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [spq_pkg::PAYLOAD_W-1:0]  rsp_top_payload,
   output logic [spq_pkg::PRIO_W-1:0]            rsp_top_prio,
   output logic                                  rsp_is_empty,
   output logic                                  rsp_is_full,
   output logic [spq_pkg::OCC_W-1:0]             rsp_occupancy,
   output logic [spq_pkg::STATUS_W-1:0]          rsp_status
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Control state
   logic [CNT_W-1:0]                     count_ff, count_in;
   logic                                 pend_ff, pend_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   spq_pkg::status_type                  status_ff, status_in;

   // Response payload registers
   logic signed [spq_pkg::PAYLOAD_W-1:0] top_payload_ff;
   logic [spq_pkg::PRIO_W-1:0]           top_prio_ff;
   logic                                 is_empty_ff, is_full_ff;
   logic [spq_pkg::OCC_W-1:0]            occupancy_ff;
   spq_pkg::status_type                  rsp_status_ff;

   logic                                 accept, load, full_now, ins_ok, rem_ok;
   spq_pkg::cell_ctrl_type               ctrl;

   logic [CAPACITY-1:0]                  cell_keep;
   logic [spq_pkg::PRIO_W-1:0]           cell_prio [CAPACITY];
   logic signed [spq_pkg::PAYLOAD_W-1:0] cell_payload [CAPACITY];

   logic [spq_pkg::PRIO_W-1:0]           tail_prio;
   logic signed [spq_pkg::PAYLOAD_W-1:0] tail_payload;

   // One request in the chain at a time; the response slot decouples the output.
   assign req_stall = pend_ff;
   assign accept    = req_valid && !req_stall;
   assign full_now  = (count_ff == CNT_W'(CAPACITY));
   assign ins_ok    = accept && (req_opcode == spq_pkg::OP_INSERT) && !full_now;
   assign rem_ok    = accept && (req_opcode == spq_pkg::OP_REMOVE) && (count_ff != '0);
   assign load      = pend_ff && (!rsp_valid_ff || !rsp_stall);

   assign ctrl.ins_en  = ins_ok;
   assign ctrl.prio    = req_prio;
   assign ctrl.payload = req_payload;

   // Cell chain: index 0 holds the lowest priority. On insert every cell past
   // the insertion point takes its left neighbour; the first such cell takes
   // the new entry. Remove only shortens the count.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                                 left_keep;
      logic [spq_pkg::PRIO_W-1:0]           left_prio;
      logic signed [spq_pkg::PAYLOAD_W-1:0] left_payload;

      if (i == 0) begin : g_head
         assign left_keep    = 1'b1;
         assign left_prio    = req_prio;
         assign left_payload = req_payload;
      end else begin : g_body
         assign left_keep    = cell_keep[i-1];
         assign left_prio    = cell_prio[i-1];
         assign left_payload = cell_payload[i-1];
      end

      spq_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .occupied     (count_ff > CNT_W'(i)),
         .left_keep    (left_keep),
         .left_prio    (left_prio),
         .left_payload (left_payload),
         .keep         (cell_keep[i]),
         .prio         (cell_prio[i]),
         .payload      (cell_payload[i])
      );
   end

   // Tail select: only the cell at count-1 contributes; empty reads as zero.
   always_comb begin
      tail_prio    = '0;
      tail_payload = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (count_ff == CNT_W'(i + 1)) begin
            tail_prio    = tail_prio | cell_prio[i];
            tail_payload = tail_payload | cell_payload[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ins_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rem_ok) begin
         count_in = count_ff - CNT_W'(1);
      end

      status_in = status_ff;
      if (accept) begin
         if (req_opcode == spq_pkg::OP_INSERT) begin
            status_in = full_now ? spq_pkg::STATUS_FULL_INSERT : spq_pkg::STATUS_OK;
         end else begin
            status_in = (count_ff == '0) ? spq_pkg::STATUS_EMPTY_REMOVE
                                         : spq_pkg::STATUS_OK;
         end
      end

      pend_in      = accept || (pend_ff && !load);
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= spq_pkg::STATUS_OK;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   // Load the response once the chain has settled; hold it while stalled.
   always_ff @(posedge clock) begin
      if (load) begin
         top_payload_ff <= tail_payload;
         top_prio_ff    <= tail_prio;
         is_empty_ff    <= (count_ff == '0);
         is_full_ff     <= full_now;
         occupancy_ff   <= spq_pkg::OCC_W'(count_ff);
         rsp_status_ff  <= status_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_top_payload = top_payload_ff;
   assign rsp_top_prio    = top_prio_ff;
   assign rsp_is_empty    = is_empty_ff;
   assign rsp_is_full     = is_full_ff;
   assign rsp_occupancy   = occupancy_ff;
   assign rsp_status      = rsp_status_ff;

   // Count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   // A dropped insert is only reported against a full queue.
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == spq_pkg::STATUS_FULL_INSERT) |-> rsp_is_full)
      else $error("insert dropped while not full");

   // An ignored remove is only reported against an empty queue.
   a_remove_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == spq_pkg::STATUS_EMPTY_REMOVE) |-> rsp_is_empty)
      else $error("remove ignored while not empty");

   // An empty queue reports a zero tail.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_top_prio == '0) && (rsp_top_payload == '0))
      else $error("empty response with non-zero tail");

   // Every accepted request leaves a response pending.
   a_pending: assert property (@(posedge clock) disable iff (reset)
      accept |=> pend_ff)
      else $error("accepted request not pending");

endmodule
